// ----- sv/aled_pkg.sv -----
// Shared types and constants for the addressable LED bit encoder.
`default_nettype none
package aled_pkg;

  localparam int unsigned ByteWidth      = 8;
  localparam int unsigned TickWidth      = 8;
  localparam int unsigned SymbolsPerByte = 8;
  localparam int unsigned SymIdxWidth    = $clog2(SymbolsPerByte);
  localparam int unsigned ApbAddrWidth   = 5;
  localparam int unsigned ApbDataWidth   = 32;
  localparam int unsigned RegIdxWidth    = 3;

  localparam logic [ByteWidth-1:0] BrightnessReset    = 8'd255;
  localparam logic [TickWidth-1:0] ZeroHighTicksReset = 8'd8;
  localparam logic [TickWidth-1:0] ZeroLowTicksReset  = 8'd17;
  localparam logic [TickWidth-1:0] OneHighTicksReset  = 8'd16;
  localparam logic [TickWidth-1:0] OneLowTicksReset   = 8'd9;

  localparam logic [SymIdxWidth-1:0] LastSymIdx = SymIdxWidth'(SymbolsPerByte - 1);

  typedef enum logic [RegIdxWidth-1:0] {
    REG_BRIGHTNESS = 3'd0,
    REG_ZERO_HIGH  = 3'd1,
    REG_ZERO_LOW   = 3'd2,
    REG_ONE_HIGH   = 3'd3,
    REG_ONE_LOW    = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [ByteWidth-1:0] brightness;
    logic [TickWidth-1:0] zero_high_ticks;
    logic [TickWidth-1:0] zero_low_ticks;
    logic [TickWidth-1:0] one_high_ticks;
    logic [TickWidth-1:0] one_low_ticks;
  } cfg_t;

endpackage
`default_nettype wire

// ----- sv/aled_byte_if.sv -----
// Valid/ready channel carrying colour bytes.
`default_nettype none
interface aled_byte_if;
  logic                            valid;
  logic                            ready;
  logic [aled_pkg::ByteWidth-1:0]  color_byte;
  logic                            last_byte;

  modport source (output valid, output color_byte, output last_byte, input ready);
  modport sink   (input valid, input color_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ----- sv/aled_sym_if.sv -----
// Valid/ready channel carrying line symbols.
`default_nettype none
interface aled_sym_if;
  logic                            valid;
  logic                            ready;
  logic                            bit_value;
  logic [aled_pkg::TickWidth-1:0]  high_ticks;
  logic [aled_pkg::TickWidth-1:0]  low_ticks;
  logic                            byte_done;
  logic                            frame_done;

  modport source (output valid, output bit_value, output high_ticks, output low_ticks,
                  output byte_done, output frame_done, input ready);
  modport sink   (input valid, input bit_value, input high_ticks, input low_ticks,
                  input byte_done, input frame_done, output ready);
endinterface
`default_nettype wire

// ----- sv/aled_cfg_regs.sv -----
// APB register block for brightness and symbol timing.
`default_nettype none
module aled_cfg_regs (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [aled_pkg::ApbAddrWidth-1:0]   paddr,
  input  wire logic [aled_pkg::ApbDataWidth-1:0]   pwdata,
  output      logic [aled_pkg::ApbDataWidth-1:0]   prdata,
  output      logic                                pready,
  output      aled_pkg::cfg_t                      cfg_o
);

  aled_pkg::cfg_t   cfg_q, cfg_d;
  aled_pkg::reg_idx_e reg_idx;
  logic             wr_en;
  logic [aled_pkg::ByteWidth-1:0] wr_byte;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = aled_pkg::reg_idx_e'(paddr[aled_pkg::ApbAddrWidth-1:2]);
  assign wr_byte = pwdata[aled_pkg::ByteWidth-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        aled_pkg::REG_BRIGHTNESS: cfg_d.brightness      = wr_byte;
        aled_pkg::REG_ZERO_HIGH:  cfg_d.zero_high_ticks = wr_byte;
        aled_pkg::REG_ZERO_LOW:   cfg_d.zero_low_ticks  = wr_byte;
        aled_pkg::REG_ONE_HIGH:   cfg_d.one_high_ticks  = wr_byte;
        aled_pkg::REG_ONE_LOW:    cfg_d.one_low_ticks   = wr_byte;
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      aled_pkg::REG_BRIGHTNESS: prdata[aled_pkg::ByteWidth-1:0] = cfg_q.brightness;
      aled_pkg::REG_ZERO_HIGH:  prdata[aled_pkg::TickWidth-1:0] = cfg_q.zero_high_ticks;
      aled_pkg::REG_ZERO_LOW:   prdata[aled_pkg::TickWidth-1:0] = cfg_q.zero_low_ticks;
      aled_pkg::REG_ONE_HIGH:   prdata[aled_pkg::TickWidth-1:0] = cfg_q.one_high_ticks;
      aled_pkg::REG_ONE_LOW:    prdata[aled_pkg::TickWidth-1:0] = cfg_q.one_low_ticks;
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brightness      <= aled_pkg::BrightnessReset;
      cfg_q.zero_high_ticks <= aled_pkg::ZeroHighTicksReset;
      cfg_q.zero_low_ticks  <= aled_pkg::ZeroLowTicksReset;
      cfg_q.one_high_ticks  <= aled_pkg::OneHighTicksReset;
      cfg_q.one_low_ticks   <= aled_pkg::OneLowTicksReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ----- sv/addressable_led_bit_encoder.sv -----
// Top level of the addressable LED bit encoder.
// Each accepted colour byte is scaled by brightness as (byte*(brightness+1))>>8 on the
// way into a one-byte holding register, then sent as eight symbols, most significant bit
// first, each carrying its bit and the high/low tick counts for that bit value; the
// eighth symbol flags byte_done, and frame_done when the byte closed the frame. The
// symbol channel sets the rate: each byte takes as long as the sink needs to accept its eight symbols.
// The holding register takes the next byte while the current one is still going out,
// so the sink sees symbols in every cycle across byte boundaries. Timing and brightness
// registers are written over APB and should only change while the encoder is idle.
`default_nettype none
module addressable_led_bit_encoder (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  aled_byte_if.sink                                byte_i,
  aled_sym_if.source                               sym_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [aled_pkg::ApbAddrWidth-1:0]   paddr,
  input  wire logic [aled_pkg::ApbDataWidth-1:0]   pwdata,
  output      logic [aled_pkg::ApbDataWidth-1:0]   prdata,
  output      logic                                pready
);

  aled_pkg::cfg_t cfg;

  aled_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Holding stage: scaled byte waiting for the serializer.
  logic                              hold_valid_q, hold_valid_d;
  logic [aled_pkg::ByteWidth-1:0]    hold_byte_q;
  logic                              hold_last_q;
  // Serializer / output register.
  logic                              sym_valid_q, sym_valid_d;
  logic [aled_pkg::ByteWidth-1:0]    shift_q, shift_d;
  logic [aled_pkg::SymIdxWidth-1:0]  idx_q, idx_d;
  logic                              last_q, last_d;

  logic                              in_fire, out_fire, at_last_sym, load;
  logic [aled_pkg::ByteWidth:0]      bright_p1;
  logic [2*aled_pkg::ByteWidth:0]    product;
  logic [aled_pkg::ByteWidth-1:0]    scaled;

  assign bright_p1 = {1'b0, cfg.brightness} + (aled_pkg::ByteWidth+1)'(1);
  assign product   = (2*aled_pkg::ByteWidth+1)'(byte_i.color_byte)
                   * (2*aled_pkg::ByteWidth+1)'(bright_p1);
  assign scaled    = product[2*aled_pkg::ByteWidth-1:aled_pkg::ByteWidth];

  assign at_last_sym = (idx_q == aled_pkg::LastSymIdx);
  assign out_fire    = sym_valid_q & sym_o.ready;
  // Pull the held byte when the symbol register is free or finishing its eighth beat.
  assign load        = hold_valid_q & (~sym_valid_q | (out_fire & at_last_sym));
  assign byte_i.ready = ~hold_valid_q | load;
  assign in_fire     = byte_i.valid & byte_i.ready;

  assign hold_valid_d = in_fire | (hold_valid_q & ~load);

  always_comb begin
    sym_valid_d = sym_valid_q;
    shift_d     = shift_q;
    idx_d       = idx_q;
    last_d      = last_q;
    if (load) begin
      sym_valid_d = 1'b1;
      shift_d     = hold_byte_q;
      idx_d       = '0;
      last_d      = hold_last_q;
    end else if (out_fire) begin
      if (at_last_sym) begin
        sym_valid_d = 1'b0;
      end else begin
        shift_d = {shift_q[aled_pkg::ByteWidth-2:0], 1'b0};
        idx_d   = idx_q + aled_pkg::SymIdxWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      sym_valid_q  <= 1'b0;
      idx_q        <= '0;
    end else begin
      hold_valid_q <= hold_valid_d;
      sym_valid_q  <= sym_valid_d;
      idx_q        <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      hold_byte_q <= scaled;
      hold_last_q <= byte_i.last_byte;
    end
    shift_q <= shift_d;
    last_q  <= last_d;
  end

  assign sym_o.valid      = sym_valid_q;
  assign sym_o.bit_value  = shift_q[aled_pkg::ByteWidth-1];
  assign sym_o.high_ticks = shift_q[aled_pkg::ByteWidth-1] ? cfg.one_high_ticks
                                                           : cfg.zero_high_ticks;
  assign sym_o.low_ticks  = shift_q[aled_pkg::ByteWidth-1] ? cfg.one_low_ticks
                                                           : cfg.zero_low_ticks;
  assign sym_o.byte_done  = at_last_sym;
  assign sym_o.frame_done = at_last_sym & last_q;

`ifndef ASSERT_OFF
  a_idx_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !at_last_sym && !load) |=>
      (sym_valid_q && idx_q == aled_pkg::SymIdxWidth'($past(idx_q) + 1'b1)))
    else $error("symbol index did not advance after a beat");

  a_load_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (sym_valid_q && idx_q == '0))
    else $error("byte load did not restart at the first symbol");

  a_hold_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_valid_q && !load) |=> (hold_valid_q && $stable(hold_byte_q)))
    else $error("held byte lost before it reached the serializer");

  a_no_mid_byte_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sym_valid_q && !at_last_sym) |-> !load)
    else $error("new byte loaded in the middle of a byte");
`endif

endmodule
`default_nettype wire
